// ===== rtl/core/lcts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcts_pkg
// Types, codes and small arithmetic helpers shared by the tuner search
// sequencer modules.
// ----------------------------------------------------------------------------
package lcts_pkg;

    localparam int POS_W = 8;
    localparam int SWR_W = 14;

    localparam logic [SWR_W-1:0] SWR_MAX   = 14'd9999;
    localparam logic [SWR_W-1:0] SWR_INIT  = 14'd10000;
    localparam logic [SWR_W-1:0] THR_RESET = 14'd120;

    localparam logic [1:0] RT_NONE  = 2'd0;
    localparam logic [1:0] RT_SWEEP = 2'd1;
    localparam logic [1:0] RT_CLIMB = 2'd2;

    localparam logic [1:0] AX_CAP  = 2'd0;
    localparam logic [1:0] AX_IND  = 2'd1;
    localparam logic [1:0] AX_BOTH = 2'd2;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_UP1   = 2'd1;
    localparam logic [1:0] PH_UP    = 2'd2;
    localparam logic [1:0] PH_DOWN  = 2'd3;

    localparam logic [1:0] PASS_FIRST  = 2'd0;
    localparam logic [1:0] PASS_SECOND = 2'd1;
    localparam logic [1:0] PASS_FINAL  = 2'd2;

    localparam logic [1:0] SETTLE_NONE  = 2'd0;
    localparam logic [1:0] SETTLE_SHORT = 2'd1;
    localparam logic [1:0] SETTLE_LONG  = 2'd2;

    localparam logic FUNC_START = 1'b0;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_ZERO   = 16'h0002,
        S_CT_CAP = 16'h0004,
        S_CT_IND = 16'h0008,
        S_CHK1   = 16'h0010,
        S_TEST_B = 16'h0020,
        S_B_CAP  = 16'h0040,
        S_CHK2   = 16'h0080,
        S_TEST_C = 16'h0100,
        S_CHK3   = 16'h0200,
        S_PICK   = 16'h0400,
        S_SUB    = 16'h0800,
        S_SH1    = 16'h1000,
        S_SH2    = 16'h2000,
        S_PASS   = 16'h4000,
        S_REVERT = 16'h8000
    } t_step;

    typedef struct packed {
        logic             func;
        logic [SWR_W-1:0] swr_value;
    } t_in_item;

    typedef struct packed {
        logic [6:0] ind_setting;
        logic [6:0] cap_setting;
        logic       side_select;
        logic [1:0] settle_code;
        logic       measure_request;
        logic       tune_done;
    } t_out_item;

    typedef struct packed {
        t_step                       step;
        logic [POS_W-1:0]            ind_now;
        logic [POS_W-1:0]            cap_now;
        logic                        side_now;
        logic [SWR_W-1:0]            first_swr;
        logic [POS_W-1:0]            first_ind;
        logic [POS_W-1:0]            first_cap;
        logic [2:0][SWR_W-1:0]       cp_swr;
        logic [2:0][POS_W-1:0]       cp_ind;
        logic [2:0][POS_W-1:0]       cp_cap;
        logic [SWR_W-1:0]            best_swr;
        logic [POS_W-1:0]            best_pos;
        logic [POS_W-1:0]            climb_step;
        logic                        cap_first;
        logic [1:0]                  kind;
        logic [1:0]                  axis;
        logic [1:0]                  phase;
        logic [1:0]                  pass_no;
        logic [POS_W-1:0]            last_ind;
        logic [POS_W-1:0]            last_cap;
        logic                        last_side;
    } t_seq_state;

    // Quotient by ten through a reciprocal; exact for all values up to 9999.
    function automatic logic [9:0] div10_swr(input logic [SWR_W-1:0] v);
        logic [26:0] p;
        p = 27'(v) * 27'd6554;
        return p[25:16];
    endfunction

    // Climb step: a tenth of the position, at least one.
    function automatic logic [POS_W-1:0] step_of(input logic [POS_W-1:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd205;
        return (p[15:11] == 5'd0) ? POS_W'(1) : POS_W'(p[15:11]);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lcts_seq_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcts_seq_core
// Next-state and result logic of the search sequencer for one transaction.
// ----------------------------------------------------------------------------
module lcts_seq_core #(
    parameter int RELAY_MAX    = 127,
    parameter int COARSE_LIMIT = 64
) (
    input  lcts_pkg::t_seq_state     i_cur,
    input  lcts_pkg::t_in_item       i_item,
    input  logic [13:0]              i_threshold,
    output lcts_pkg::t_seq_state     o_next,
    output logic                     o_res_valid,
    output lcts_pkg::t_out_item      o_res
);
    import lcts_pkg::*;

    localparam logic [9:0] RMAX = 10'(RELAY_MAX);
    localparam logic [9:0] CLIM = 10'(COARSE_LIMIT);

    always_comb begin : p_step
        t_seq_state       s;
        logic [SWR_W-1:0] v;
        logic             good;
        logic [9:0]       q;
        logic [POS_W-1:0] x;
        logic [9:0]       pos;
        logic [9:0]       nx;
        logic             go_run;
        logic             do_end;
        logic [POS_W-1:0] end_pos;
        logic             emit;
        logic             emit_long;
        logic             emit_done;
        logic [1:0]       k;

        s         = i_cur;
        v         = (i_item.swr_value > SWR_MAX) ? SWR_MAX : i_item.swr_value;
        good      = v <= i_threshold;
        q         = div10_swr(v);
        x         = '0;
        pos       = '0;
        nx        = '0;
        go_run    = 1'b0;
        do_end    = 1'b0;
        end_pos   = '0;
        emit      = 1'b0;
        emit_long = 1'b0;
        emit_done = 1'b0;
        k         = 2'd0;

        if (i_item.func == FUNC_START) begin
            s.kind    = RT_NONE;
            s.pass_no = PASS_FIRST;
            s.step    = S_ZERO;
            go_run    = 1'b1;
        end else if (s.step != S_IDLE) begin
            if (s.kind == RT_SWEEP) begin
                if (s.phase == PH_START) begin
                    s.best_swr = SWR_W'(q);
                    s.best_pos = '0;
                    pos        = 10'd1;
                end else begin
                    pos = 10'((s.axis == AX_CAP) ? s.cap_now : s.ind_now);
                    if (SWR_W'(q) > s.best_swr) begin
                        do_end  = 1'b1;
                        end_pos = s.best_pos;
                    end else begin
                        s.best_swr = SWR_W'(q);
                        s.best_pos = POS_W'(pos);
                        pos        = {pos[8:0], 1'b0};
                    end
                end
                if (!do_end) begin
                    if (pos < CLIM && pos <= RMAX) begin
                        if (s.axis != AX_IND) s.cap_now = POS_W'(pos);
                        if (s.axis != AX_CAP) s.ind_now = POS_W'(pos);
                        s.phase = PH_UP1;
                        emit    = 1'b1;
                    end else begin
                        do_end  = 1'b1;
                        end_pos = s.best_pos;
                    end
                end
            end else if (s.kind == RT_CLIMB) begin
                x = (s.axis == AX_CAP) ? s.cap_now : s.ind_now;
                if (s.phase == PH_START) begin
                    s.best_pos   = x;
                    s.climb_step = step_of(x);
                    s.best_swr   = v;
                    nx           = 10'(x) + 10'(s.climb_step);
                    if (nx > RMAX) nx = RMAX;
                    if (s.axis != AX_IND) s.cap_now = POS_W'(nx);
                    if (s.axis != AX_CAP) s.ind_now = POS_W'(nx);
                    s.phase = PH_UP1;
                    emit    = 1'b1;
                end else begin
                    if (s.phase == PH_UP1) begin
                        if (v <= s.best_swr) begin
                            s.best_swr = v;
                            s.best_pos = x;
                            s.phase    = PH_UP;
                        end else begin
                            s.best_swr = v;
                            s.phase    = PH_DOWN;
                        end
                    end else if (v > s.best_swr) begin
                        do_end  = 1'b1;
                        end_pos = s.best_pos;
                    end else begin
                        s.best_swr   = v;
                        s.best_pos   = x;
                        s.climb_step = step_of(x);
                    end
                    if (!do_end) begin
                        if (s.phase == PH_UP) begin
                            if (10'(x) + {1'b0, s.climb_step, 1'b0} <= RMAX) begin
                                nx   = 10'(x) + 10'(s.climb_step);
                                emit = 1'b1;
                            end
                        end else if (10'(x) >= {1'b0, s.climb_step, 1'b0}) begin
                            nx   = 10'(x) - 10'(s.climb_step);
                            emit = 1'b1;
                        end
                        if (emit) begin
                            if (s.axis != AX_IND) s.cap_now = POS_W'(nx);
                            if (s.axis != AX_CAP) s.ind_now = POS_W'(nx);
                        end else begin
                            do_end  = 1'b1;
                            end_pos = s.best_pos;
                        end
                    end
                end
            end else begin
                go_run = 1'b1;
                unique case (s.step)
                    S_ZERO: begin
                        if (good) begin
                            emit_done = 1'b1;
                        end else begin
                            s.cp_swr[0] = SWR_INIT;
                            s.cp_swr[1] = SWR_INIT;
                            s.cp_swr[2] = SWR_INIT;
                            s.step      = S_CT_CAP;
                        end
                    end
                    S_CHK1, S_CHK2, S_CHK3: begin
                        if (good) begin
                            emit_done = 1'b1;
                        end else begin
                            k = (s.step == S_CHK1) ? 2'd0 :
                                (s.step == S_CHK2) ? 2'd1 : 2'd2;
                            s.cp_swr[k] = v;
                            s.cp_ind[k] = s.ind_now;
                            s.cp_cap[k] = s.cap_now;
                            s.step = (k == 2'd0) ? S_TEST_B :
                                     (k == 2'd1) ? S_TEST_C : S_PICK;
                        end
                    end
                    S_SUB: begin
                        if (good) emit_done = 1'b1;
                        else s.step = S_SH1;
                    end
                    S_PASS: begin
                        if (s.pass_no == PASS_FIRST) begin
                            if (good) begin
                                emit_done = 1'b1;
                            end else begin
                                s.first_swr = v;
                                s.first_ind = s.ind_now;
                                s.first_cap = s.cap_now;
                                s.side_now  = ~s.side_now;
                                s.pass_no   = PASS_SECOND;
                                s.step      = S_ZERO;
                            end
                        end else if (s.pass_no == PASS_SECOND) begin
                            if (v > s.first_swr) begin
                                s.side_now = ~s.side_now;
                                s.ind_now  = s.first_ind;
                                s.cap_now  = s.first_cap;
                                s.step     = S_REVERT;
                            end else if (good) begin
                                emit_done = 1'b1;
                            end else begin
                                s.pass_no = PASS_FINAL;
                                s.step    = S_SH1;
                            end
                        end else begin
                            emit_done = 1'b1;
                        end
                    end
                    S_REVERT: begin
                        if (good) begin
                            emit_done = 1'b1;
                        end else begin
                            s.pass_no = PASS_FINAL;
                            s.step    = S_SH1;
                        end
                    end
                    default: emit_done = 1'b1;
                endcase
                if (emit_done) begin
                    go_run = 1'b0;
                    s.kind = RT_NONE;
                    s.step = S_IDLE;
                end
            end
        end

        if (do_end) begin
            if (s.axis != AX_IND) s.cap_now = end_pos;
            if (s.axis != AX_CAP) s.ind_now = end_pos;
            s.kind = RT_NONE;
            go_run = 1'b1;
        end

        for (int it = 0; it < 5; it++) begin
            if (go_run) begin
                go_run = 1'b0;
                unique case (s.step)
                    S_ZERO: begin
                        s.ind_now = '0;
                        s.cap_now = '0;
                        emit_long = 1'b1;
                    end
                    S_CHK1, S_CHK2, S_CHK3, S_SUB, S_PASS, S_REVERT: emit = 1'b1;
                    S_CT_CAP: begin
                        s.step = S_CT_IND;
                        s.kind = RT_SWEEP;
                        s.axis = AX_CAP;
                        s.phase = PH_START;
                        emit = 1'b1;
                    end
                    S_CT_IND: begin
                        s.step = S_CHK1;
                        s.kind = RT_SWEEP;
                        s.axis = AX_IND;
                        s.phase = PH_START;
                        emit = 1'b1;
                    end
                    S_TEST_B: begin
                        if (s.cap_now <= POS_W'(2) && s.ind_now <= POS_W'(2)) begin
                            s.ind_now = '0;
                            s.cap_now = '0;
                            s.step = S_B_CAP;
                            s.kind = RT_SWEEP;
                            s.axis = AX_IND;
                            s.phase = PH_START;
                            emit = 1'b1;
                        end else begin
                            s.step = S_TEST_C;
                            go_run = 1'b1;
                        end
                    end
                    S_B_CAP: begin
                        s.step = S_CHK2;
                        s.kind = RT_SWEEP;
                        s.axis = AX_CAP;
                        s.phase = PH_START;
                        emit = 1'b1;
                    end
                    S_TEST_C: begin
                        if (s.cap_now <= POS_W'(2) && s.ind_now <= POS_W'(2)) begin
                            s.ind_now = '0;
                            s.cap_now = '0;
                            s.step = S_CHK3;
                            s.kind = RT_SWEEP;
                            s.axis = AX_BOTH;
                            s.phase = PH_START;
                            emit = 1'b1;
                        end else begin
                            s.step = S_PICK;
                            go_run = 1'b1;
                        end
                    end
                    S_PICK: begin
                        if (s.cp_swr[0] <= s.cp_swr[1] && s.cp_swr[0] <= s.cp_swr[2])
                            k = 2'd0;
                        else if (s.cp_swr[1] <= s.cp_swr[0] && s.cp_swr[1] <= s.cp_swr[2])
                            k = 2'd1;
                        else
                            k = 2'd2;
                        s.cap_now = s.cp_cap[k];
                        s.ind_now = s.cp_ind[k];
                        s.step = S_SUB;
                        go_run = 1'b1;
                    end
                    S_SH1: begin
                        s.cap_first = s.cap_now >= s.ind_now;
                        s.step = S_SH2;
                        s.kind = RT_CLIMB;
                        s.axis = s.cap_first ? AX_CAP : AX_IND;
                        s.phase = PH_START;
                        emit = 1'b1;
                    end
                    S_SH2: begin
                        s.step = S_PASS;
                        s.kind = RT_CLIMB;
                        s.axis = s.cap_first ? AX_IND : AX_CAP;
                        s.phase = PH_START;
                        emit = 1'b1;
                    end
                    default: begin
                        s.step = S_IDLE;
                        s.kind = RT_NONE;
                    end
                endcase
            end
        end

        o_res.ind_setting     = s.ind_now[6:0];
        o_res.cap_setting     = s.cap_now[6:0];
        o_res.side_select     = s.side_now;
        o_res.measure_request = emit | emit_long;
        o_res.tune_done       = emit_done;
        if (emit_long)
            o_res.settle_code = SETTLE_LONG;
        else if (emit && (s.ind_now != s.last_ind || s.cap_now != s.last_cap ||
                          s.side_now != s.last_side))
            o_res.settle_code = SETTLE_SHORT;
        else
            o_res.settle_code = SETTLE_NONE;
        o_res_valid = emit | emit_long | emit_done;
        if (o_res_valid) begin
            s.last_ind  = s.ind_now;
            s.last_cap  = s.cap_now;
            s.last_side = s.side_now;
        end
        o_next = s;
    end

endmodule
`default_nettype wire

// ===== rtl/core/lcts_out_skid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcts_out_skid
// Result register with one skid entry, so that a transaction can be accepted
// while the previous result still waits.
// ----------------------------------------------------------------------------
module lcts_out_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lcts_pkg::t_out_item i_data,
    input  logic                i_stall,
    output logic                o_valid,
    output lcts_pkg::t_out_item o_data,
    output logic                o_full
);
    import lcts_pkg::*;

    logic      r_ovalid;
    logic      r_svalid;
    t_out_item r_odata;
    t_out_item r_sdata;
    logic      take;

    assign take    = r_ovalid & ~i_stall;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_full  = r_svalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_svalid <= 1'b0;
        end else if (!r_ovalid || take) begin
            if (r_svalid) begin
                r_ovalid <= 1'b1;
                r_svalid <= 1'b0;
            end else begin
                r_ovalid <= i_push;
            end
        end else if (i_push) begin
            r_svalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ovalid || take) begin
            if (r_svalid) r_odata <= r_sdata;
            else if (i_push) r_odata <= i_data;
        end else if (i_push) begin
            r_sdata <= i_data;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_svalid && !r_ovalid))
        else $error("skid entry held without an output entry");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_svalid))
        else $error("result pushed while skid entry full");
    a_push_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !r_ovalid) |=> (r_ovalid && !r_svalid))
        else $error("result pushed into empty stage was not presented");

endmodule
`default_nettype wire

// ===== rtl/core/lc_tuner_search_sequencer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lc_tuner_search_sequencer_unit
// Automatic L-network tuner search sequencer with an APB threshold register.
// ----------------------------------------------------------------------------
// One input transaction is accepted per clock while the input is not stalled.
// Each transaction is handled by a single registered step: its result, if any,
// is written into the result register on acceptance, or into the skid entry
// while an earlier result still waits to be taken. A result register with one
// skid entry lets input continue while a result waits; the input stalls only once both are full.
module lc_tuner_search_sequencer_unit #(
    parameter int RELAY_MAX    = 127,
    parameter int COARSE_LIMIT = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lcts_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lcts_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lcts_pkg::*;

    t_seq_state       r_state;
    t_seq_state       n_state;
    t_seq_state       rst_state;
    logic [SWR_W-1:0] r_threshold;
    logic             accept;
    logic             full;
    logic             res_valid;
    t_out_item        res;

    assign pready     = 1'b1;
    assign prdata     = (paddr == REG_THRESHOLD) ? 32'(r_threshold) : 32'd0;
    assign o_in_stall = full;
    assign accept     = i_in_valid & ~full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
        end else if (psel && penable && pwrite && paddr == REG_THRESHOLD) begin
            r_threshold <= pwdata[SWR_W-1:0];
        end
    end

    lcts_seq_core #(
        .RELAY_MAX    (RELAY_MAX),
        .COARSE_LIMIT (COARSE_LIMIT)
    ) u_core (
        .i_cur       (r_state),
        .i_item      (i_in_item),
        .i_threshold (r_threshold),
        .o_next      (n_state),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        rst_state            = '0;
        rst_state.step       = S_IDLE;
        rst_state.cp_swr[0]  = SWR_INIT;
        rst_state.cp_swr[1]  = SWR_INIT;
        rst_state.cp_swr[2]  = SWR_INIT;
        rst_state.climb_step = POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rst_state;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    lcts_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept & res_valid),
        .i_data  (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_item),
        .o_full  (full)
    );

endmodule
`default_nettype wire
